>>> hdl/rl2en_pkg.sv
`default_nettype none

package rl2en_pkg;

    localparam int SAMPLE_W = 16;
    localparam int RATIO_W  = 24;
    localparam int DIFF_W   = 42;
    localparam int REF_W    = 41;
    localparam int FRAC_W   = 16;
    localparam int QUO_W    = 2 * RATIO_W;
    localparam int ROOT_REM_W = RATIO_W + 2;
    localparam int CNT_W    = 6;

    localparam logic [DIFF_W-1:0]  DIFF_SUM_MAX = {DIFF_W{1'b1}};
    localparam logic [REF_W-1:0]   REF_SUM_MAX  = {REF_W{1'b1}};
    localparam logic [RATIO_W-1:0] RATIO_MAX    = {RATIO_W{1'b1}};

    localparam logic [CNT_W-1:0] DIV_LAST_STEP  = CNT_W'(QUO_W - 1);
    localparam logic [CNT_W-1:0] ROOT_LAST_STEP = CNT_W'(RATIO_W - 1);

    localparam logic STATUS_OK       = 1'b0;
    localparam logic STATUS_ZERO_DEN = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV,
        ST_ROOT_INIT,
        ST_ROOT,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic in_ready;
        logic accum;
        logic check;
        logic div_step;
        logic root_init;
        logic root_step;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic den_zero;
        logic ratio_sat;
        logic out_free;
    } t_sts;

endpackage

`default_nettype wire

>>> hdl/relative_l2_error_norm.sv
// relative L2 error norm of a streamed vector
//
// input channel: i_in_valid / o_in_ready carry one word per cycle, a pair of
// signed 16-bit samples (computed, reference) and a last flag. each word adds
// its squared difference and squared reference to two saturating sums.
// output channel: o_out_valid / i_out_ready carry one word per vector:
// o_error_ratio = sqrt(diff sum / ref sum) in unsigned Q8.16, truncated and
// saturated, and o_status (1 = zero reference energy, ratio 0).
// throughput: non-last words are taken every cycle. after a last word the
// block takes no input while a 48-step restoring divider and a 24-step
// digit-by-digit square root run, one bit or one root digit per cycle,
// before the result is loaded into the output register; when the
// reference sum is zero or the ratio saturates, both steps are skipped.
// the output register lets the next vector stream in while a result waits;
// if the receiver still stalls when the following result is ready, the
// block holds that result and takes no input until the register frees.
// reset (synchronous, active low) clears both sums and drops o_out_valid.
`default_nettype none

module relative_l2_error_norm (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_in_valid,
    output logic                                      o_in_ready,
    input  wire logic signed [rl2en_pkg::SAMPLE_W-1:0] i_computed_sample,
    input  wire logic signed [rl2en_pkg::SAMPLE_W-1:0] i_reference_sample,
    input  wire logic                                 i_last_element,
    output logic                                      o_out_valid,
    input  wire logic                                 i_out_ready,
    output logic [rl2en_pkg::RATIO_W-1:0]             o_error_ratio,
    output logic                                      o_status
);
    import rl2en_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    rl2en_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_last_element (i_last_element),
        .i_sts          (w_sts),
        .o_cmd          (w_cmd)
    );

    rl2en_dp u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (w_cmd),
        .i_computed_sample  (i_computed_sample),
        .i_reference_sample (i_reference_sample),
        .i_out_ready        (i_out_ready),
        .o_sts              (w_sts),
        .o_out_valid        (o_out_valid),
        .o_error_ratio      (o_error_ratio),
        .o_status           (o_status)
    );

    assign o_in_ready = w_cmd.in_ready;

endmodule

`default_nettype wire

>>> hdl/rl2en_ctrl.sv
`default_nettype none

module rl2en_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    input  wire logic             i_last_element,
    input  wire rl2en_pkg::t_sts  i_sts,
    output rl2en_pkg::t_cmd       o_cmd
);
    import rl2en_pkg::*;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid && i_last_element) begin
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (i_sts.den_zero || i_sts.ratio_sat) begin
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_DIV;
                    n_cnt   = DIV_LAST_STEP;
                end
            end
            ST_DIV: begin
                if (r_cnt == '0) begin
                    n_state = ST_ROOT_INIT;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            ST_ROOT_INIT: begin
                n_state = ST_ROOT;
                n_cnt   = ROOT_LAST_STEP;
            end
            ST_ROOT: begin
                if (r_cnt == '0) begin
                    n_state = ST_DONE;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            ST_DONE: begin
                if (i_sts.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd = '0;
        case (r_state)
            ST_IDLE: begin
                o_cmd.in_ready = 1'b1;
                o_cmd.accum    = i_in_valid;
            end
            ST_CHECK: begin
                o_cmd.check = 1'b1;
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
            end
            ST_ROOT_INIT: begin
                o_cmd.root_init = 1'b1;
            end
            ST_ROOT: begin
                o_cmd.root_step = 1'b1;
            end
            ST_DONE: begin
                o_cmd.out_load = i_sts.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_last_starts_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE && i_in_valid && i_last_element) |=> (r_state == ST_CHECK))
        else $error("last word did not start the result sequence");

    a_div_to_root: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV && r_cnt == '0) |=> (r_state == ST_ROOT_INIT))
        else $error("divider did not hand over to square root");
`endif

endmodule

`default_nettype wire

>>> hdl/rl2en_dp.sv
`default_nettype none

module rl2en_dp (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire rl2en_pkg::t_cmd                      i_cmd,
    input  wire logic signed [rl2en_pkg::SAMPLE_W-1:0] i_computed_sample,
    input  wire logic signed [rl2en_pkg::SAMPLE_W-1:0] i_reference_sample,
    input  wire logic                                 i_out_ready,
    output rl2en_pkg::t_sts                           o_sts,
    output logic                                      o_out_valid,
    output logic [rl2en_pkg::RATIO_W-1:0]             o_error_ratio,
    output logic                                      o_status
);
    import rl2en_pkg::*;

    logic [DIFF_W-1:0]  r_diff_sum, n_diff_sum;
    logic [REF_W-1:0]   r_ref_sum, n_ref_sum;
    logic [DIFF_W-1:0]  r_rem, n_rem;
    logic [QUO_W-1:0]   r_work, n_work;
    logic [RATIO_W-1:0] r_root, n_root;
    logic               r_res_status, n_res_status;
    logic               r_out_valid;
    logic [RATIO_W-1:0] r_error_ratio;
    logic               r_status;

    logic signed [SAMPLE_W:0]       w_diff;
    logic signed [2*SAMPLE_W+1:0]   w_diff_sq_full;
    logic signed [2*SAMPLE_W-1:0]   w_ref_sq_full;
    logic [DIFF_W:0]                w_diff_add;
    logic [REF_W:0]                 w_ref_add;
    logic [DIFF_W-1:0]              w_div_sh;
    logic [DIFF_W-1:0]              w_den_ext;
    logic                           w_div_ge;
    logic [ROOT_REM_W+1:0]          w_root_sh;
    logic [ROOT_REM_W+1:0]          w_root_trial;
    logic                           w_root_ge;
    logic [ROOT_REM_W+1:0]          w_root_diff;

    assign w_diff = $signed({i_computed_sample[SAMPLE_W-1], i_computed_sample})
                  - $signed({i_reference_sample[SAMPLE_W-1], i_reference_sample});
    assign w_diff_sq_full = w_diff * w_diff;
    assign w_ref_sq_full  = i_reference_sample * i_reference_sample;

    assign w_diff_add = {1'b0, r_diff_sum}
                      + {{(DIFF_W-2*SAMPLE_W+1){1'b0}}, w_diff_sq_full[2*SAMPLE_W-1:0]};
    assign w_ref_add  = {1'b0, r_ref_sum}
                      + {{(REF_W-2*SAMPLE_W+2){1'b0}}, w_ref_sq_full[2*SAMPLE_W-2:0]};

    assign w_div_sh  = {r_rem[DIFF_W-2:0], r_work[QUO_W-1]};
    assign w_den_ext = {1'b0, r_ref_sum};
    assign w_div_ge  = (w_div_sh >= w_den_ext);

    assign w_root_sh    = {r_rem[ROOT_REM_W-1:0], r_work[QUO_W-1 -: 2]};
    assign w_root_trial = {2'b00, r_root, 2'b01};
    assign w_root_ge    = (w_root_sh >= w_root_trial);
    assign w_root_diff  = w_root_sh - w_root_trial;

    assign o_sts.den_zero  = (r_ref_sum == '0);
    assign o_sts.ratio_sat = ({{(REF_W+FRAC_W-DIFF_W){1'b0}}, r_diff_sum}
                              >= {r_ref_sum, {FRAC_W{1'b0}}});
    assign o_sts.out_free  = !r_out_valid || i_out_ready;

    // running sums
    always_comb begin
        n_diff_sum = r_diff_sum;
        n_ref_sum  = r_ref_sum;
        if (i_cmd.accum) begin
            n_diff_sum = w_diff_add[DIFF_W] ? DIFF_SUM_MAX : w_diff_add[DIFF_W-1:0];
            n_ref_sum  = w_ref_add[REF_W] ? REF_SUM_MAX : w_ref_add[REF_W-1:0];
        end else if (i_cmd.out_load) begin
            n_diff_sum = '0;
            n_ref_sum  = '0;
        end
    end

    // divide then square root
    always_comb begin
        n_rem        = r_rem;
        n_work       = r_work;
        n_root       = r_root;
        n_res_status = r_res_status;
        if (i_cmd.check) begin
            n_rem  = {{FRAC_W{1'b0}}, r_diff_sum[DIFF_W-1:FRAC_W]};
            n_work = {r_diff_sum[FRAC_W-1:0], {(QUO_W-FRAC_W){1'b0}}};
            if (o_sts.den_zero) begin
                n_root       = '0;
                n_res_status = STATUS_ZERO_DEN;
            end else begin
                n_root       = RATIO_MAX;
                n_res_status = STATUS_OK;
            end
        end else if (i_cmd.div_step) begin
            n_rem  = w_div_ge ? (w_div_sh - w_den_ext) : w_div_sh;
            n_work = {r_work[QUO_W-2:0], w_div_ge};
        end else if (i_cmd.root_init) begin
            n_rem        = '0;
            n_root       = '0;
            n_res_status = STATUS_OK;
        end else if (i_cmd.root_step) begin
            n_rem  = {{(DIFF_W-ROOT_REM_W){1'b0}},
                      w_root_ge ? w_root_diff[ROOT_REM_W-1:0] : w_root_sh[ROOT_REM_W-1:0]};
            n_work = {r_work[QUO_W-3:0], 2'b00};
            n_root = {r_root[RATIO_W-2:0], w_root_ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_diff_sum  <= '0;
            r_ref_sum   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_diff_sum <= n_diff_sum;
            r_ref_sum  <= n_ref_sum;
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem        <= n_rem;
        r_work       <= n_work;
        r_root       <= n_root;
        r_res_status <= n_res_status;
        if (i_cmd.out_load) begin
            r_error_ratio <= r_root;
            r_status      <= r_res_status;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_error_ratio = r_error_ratio;
    assign o_status      = r_status;

`ifndef SYNTHESIS
    a_sums_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |=> (r_diff_sum == '0 && r_ref_sum == '0))
        else $error("sums not cleared after result word");

    a_zero_den_ratio: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_status == STATUS_ZERO_DEN) |-> (r_error_ratio == '0))
        else $error("zero denominator word carries nonzero ratio");
`endif

endmodule

`default_nettype wire
